// ===== hw/rtl/vlam_pkg.sv =====
// ----------------------------------------------------------------------------
// vlam_pkg
// Widths, constants and shared types of the look-at view matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package vlam_pkg;

   // Q16.16 words and normalized vector components (range -1.0 .. +1.0).
   localparam int WORD_W  = 32;
   localparam int UNIT_W  = 18;
   localparam int FRAC_W  = 16;
   localparam int DIFF_W  = WORD_W + 1;

   // Normalizer internals.
   localparam int MAG_W       = 64;
   localparam int NRM_W       = 31;
   localparam int SQ_W        = 2 * NRM_W;
   localparam int ROOT_W      = 32;
   localparam int ROOT_ITER   = 32;
   localparam int SQRT_PER_ST = 2;
   localparam int QUO_W       = FRAC_W + 1;
   localparam int DIV_PER_ST  = 2;
   localparam int REM_W       = NRM_W + FRAC_W + 1;

   // Cross products and dot products.
   localparam int PR1_W = WORD_W + UNIT_W;
   localparam int CR1_W = PR1_W + 1;
   localparam int PR2_W = 2 * UNIT_W;
   localparam int CR2_W = PR2_W + 1;
   localparam int DOT_W = PR1_W + 3;

   localparam logic [1:0] COL_LAST = 2'd3;
   localparam logic signed [WORD_W-1:0] FIX_ONE = 32'sh0001_0000;

   typedef logic [2:0][WORD_W-1:0] vec32_type;
   typedef logic [2:0][UNIT_W-1:0] vecu_type;

   typedef struct packed {
      logic       valid;
      logic       zero;
      logic [2:0] neg;
   } tag_type;

endpackage

`default_nettype wire

// ===== hw/rtl/vlam_normalize.sv =====
// ----------------------------------------------------------------------------
// vlam_normalize
// Pipelined 3-vector normalizer: scale, sum of squares, square root and
// three divisions, giving signed Q2.16 unit components. Side data rides along.
// ----------------------------------------------------------------------------
`default_nettype none

module vlam_normalize #(
   parameter int IN_W  = vlam_pkg::DIFF_W,
   parameter int AUX_W = 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire logic [2:0][IN_W-1:0]   in_vec,
   input  wire logic [AUX_W-1:0]       in_aux,
   output vlam_pkg::vecu_type          out_vec,
   output logic                        out_valid,
   output logic                        out_zero,
   output logic [AUX_W-1:0]            out_aux
);

   localparam int MAG_W    = vlam_pkg::MAG_W;
   localparam int N_SH     = 3;
   localparam int SQRT_ST  = vlam_pkg::ROOT_ITER / vlam_pkg::SQRT_PER_ST;
   localparam int DIV_ST   = (vlam_pkg::QUO_W + vlam_pkg::DIV_PER_ST - 1)
                             / vlam_pkg::DIV_PER_ST;
   localparam int ST_SQ    = N_SH + 2;
   localparam int ST_SUM   = ST_SQ + 1;
   localparam int ST_DINIT = ST_SUM + SQRT_ST + 1;
   localparam int ST_LAST  = ST_DINIT + DIV_ST + 1;

   vlam_pkg::tag_type tag_in;
   vlam_pkg::tag_type tag_ff [1:ST_LAST];
   logic [AUX_W-1:0]  aux_ff [1:ST_LAST];

   logic [IN_W-1:0]  abs_v [3];
   logic [MAG_W-1:0] sh_ff [0:N_SH][3];

   logic [vlam_pkg::NRM_W-1:0] nm_ff [ST_SQ:ST_DINIT-1][3];
   logic [vlam_pkg::SQ_W-1:0]  sq_ff [3];

   logic [MAG_W-1:0] x_ff   [0:SQRT_ST];
   logic [MAG_W-1:0] res_ff [0:SQRT_ST];

   logic [vlam_pkg::REM_W-1:0]  rem_ff [0:DIV_ST][3];
   logic [vlam_pkg::QUO_W-1:0]  q_ff   [0:DIV_ST][3];
   logic [vlam_pkg::ROOT_W-1:0] len_ff [0:DIV_ST];

   vlam_pkg::vecu_type out_ff;

   // Magnitudes and signs.
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         abs_v[i] = in_vec[i][IN_W-1] ? IN_W'(-signed'(in_vec[i])) : in_vec[i];
      end
      tag_in.valid = in_valid;
      tag_in.zero  = (in_vec[0] == '0) && (in_vec[1] == '0) && (in_vec[2] == '0);
      for (int i = 0; i < 3; i++) begin
         tag_in.neg[i] = in_vec[i][IN_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= ST_LAST; k++) begin
            tag_ff[k] <= '0;
         end
      end else begin
         tag_ff[1] <= tag_in;
         for (int k = 2; k <= ST_LAST; k++) begin
            tag_ff[k] <= tag_ff[k-1];
         end
      end
      aux_ff[1] <= in_aux;
      for (int k = 2; k <= ST_LAST; k++) begin
         aux_ff[k] <= aux_ff[k-1];
      end
      for (int i = 0; i < 3; i++) begin
         sh_ff[0][i] <= MAG_W'(abs_v[i]);
      end
   end

   // Leading-zero shift: the OR of the three magnitudes is moved up until
   // its top bit is set, two binary steps per stage.
   for (genvar k = 0; k < N_SH; k++) begin : g_shift
      localparam int SA = (MAG_W / 2) >> (2 * k);
      localparam int SB = SA / 2;
      logic [MAG_W-1:0] a [3];
      logic [MAG_W-1:0] b [3];
      logic [MAG_W-1:0] oa;
      logic [MAG_W-1:0] ob;

      always_comb begin
         oa = sh_ff[k][0] | sh_ff[k][1] | sh_ff[k][2];
         for (int i = 0; i < 3; i++) begin
            a[i] = (~|oa[MAG_W-1 -: SA]) ? (sh_ff[k][i] << SA) : sh_ff[k][i];
         end
         ob = a[0] | a[1] | a[2];
         for (int i = 0; i < 3; i++) begin
            b[i] = (~|ob[MAG_W-1 -: SB]) ? (a[i] << SB) : a[i];
         end
      end

      always_ff @(posedge clock) begin
         sh_ff[k+1] <= b;
      end
   end

   // Squares, then their sum. The top bits keep the largest component in
   // [2^30, 2^31), truncating whatever falls below.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nm_ff[ST_SQ][i] <= sh_ff[N_SH][i][MAG_W-1 -: vlam_pkg::NRM_W];
         sq_ff[i] <= vlam_pkg::SQ_W'(sh_ff[N_SH][i][MAG_W-1 -: vlam_pkg::NRM_W])
                   * vlam_pkg::SQ_W'(sh_ff[N_SH][i][MAG_W-1 -: vlam_pkg::NRM_W]);
      end
      for (int k = ST_SQ + 1; k < ST_DINIT; k++) begin
         nm_ff[k] <= nm_ff[k-1];
      end
      x_ff[0]   <= MAG_W'(sq_ff[0]) + MAG_W'(sq_ff[1]) + MAG_W'(sq_ff[2]);
      res_ff[0] <= '0;
   end

   // Floor square root, two result bits per stage.
   for (genvar r = 0; r < SQRT_ST; r++) begin : g_sqrt
      logic [MAG_W-1:0] x;
      logic [MAG_W-1:0] res;
      logic [MAG_W-1:0] bitv;

      always_comb begin
         x    = x_ff[r];
         res  = res_ff[r];
         bitv = '0;
         for (int t = 0; t < vlam_pkg::SQRT_PER_ST; t++) begin
            bitv = MAG_W'(1) << (MAG_W - 2 - 2 * (r * vlam_pkg::SQRT_PER_ST + t));
            if (x >= res + bitv) begin
               x   = x - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
         end
      end

      always_ff @(posedge clock) begin
         x_ff[r+1]   <= x;
         res_ff[r+1] <= res;
      end
   end

   // Rounded dividend: component * 2^16 + len / 2.
   always_ff @(posedge clock) begin
      len_ff[0] <= res_ff[SQRT_ST][vlam_pkg::ROOT_W-1:0];
      for (int i = 0; i < 3; i++) begin
         rem_ff[0][i] <= vlam_pkg::REM_W'({nm_ff[ST_DINIT-1][i], {vlam_pkg::FRAC_W{1'b0}}})
                       + vlam_pkg::REM_W'(res_ff[SQRT_ST][vlam_pkg::ROOT_W-1:1]);
         q_ff[0][i]   <= '0;
      end
   end

   // Restoring division, quotient bits from the top, two per stage.
   for (genvar d = 0; d < DIV_ST; d++) begin : g_div
      logic [vlam_pkg::REM_W-1:0] rem [3];
      logic [vlam_pkg::QUO_W-1:0] q   [3];
      logic [vlam_pkg::REM_W-1:0] dv;

      always_comb begin
         dv = '0;
         for (int i = 0; i < 3; i++) begin
            rem[i] = rem_ff[d][i];
            q[i]   = q_ff[d][i];
         end
         for (int t = 0; t < vlam_pkg::DIV_PER_ST; t++) begin
            if (d * vlam_pkg::DIV_PER_ST + t < vlam_pkg::QUO_W) begin
               dv = vlam_pkg::REM_W'(len_ff[d])
                    << (vlam_pkg::QUO_W - 1 - (d * vlam_pkg::DIV_PER_ST + t));
               for (int i = 0; i < 3; i++) begin
                  if (rem[i] >= dv) begin
                     rem[i] = rem[i] - dv;
                     q[i]   = {q[i][vlam_pkg::QUO_W-2:0], 1'b1};
                  end else begin
                     q[i]   = {q[i][vlam_pkg::QUO_W-2:0], 1'b0};
                  end
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         len_ff[d+1] <= len_ff[d];
         rem_ff[d+1] <= rem;
         q_ff[d+1]   <= q;
      end
   end

   // Signs back on; a zero vector gives zero, whatever the divider did.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         if (tag_ff[ST_LAST-1].zero) begin
            out_ff[i] <= '0;
         end else if (tag_ff[ST_LAST-1].neg[i]) begin
            out_ff[i] <= -{1'b0, q_ff[DIV_ST][i]};
         end else begin
            out_ff[i] <= {1'b0, q_ff[DIV_ST][i]};
         end
      end
   end

   assign out_vec   = out_ff;
   assign out_valid = tag_ff[ST_LAST].valid;
   assign out_zero  = tag_ff[ST_LAST].zero;
   assign out_aux   = aux_ff[ST_LAST];

endmodule

`default_nettype wire

// ===== hw/rtl/view_look_at_matrix_top.sv =====
// ----------------------------------------------------------------------------
// view_look_at_matrix_top
// Left-handed look-at view matrix in signed Q16.16, emitted column by column.
//
//   channel   ports                         handshake
//   request   req_eye_*, req_target_*,      start, busy
//             req_up_*
//   result    rsp_column_index, rsp_row*,   rsp_valid strobe, one cycle each
//             rsp_degenerate, rsp_last_column
//
// Requests are pipelined; busy holds off the next request after each accept
// so that matrices never overlap at the result port, where the four columns
// of a matrix leave one per cycle. The arithmetic is a fixed pipeline of 107
// stages (three 33-stage normalizers with square root and dividers, plus
// front, cross and dot product stages).
// Reset is synchronous and clears valid bits and counters only.
// The result side is never stalled, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module view_look_at_matrix_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_eye_x,
   input  wire logic [31:0] req_eye_y,
   input  wire logic [31:0] req_eye_z,
   input  wire logic [31:0] req_target_x,
   input  wire logic [31:0] req_target_y,
   input  wire logic [31:0] req_target_z,
   input  wire logic [31:0] req_up_x,
   input  wire logic [31:0] req_up_y,
   input  wire logic [31:0] req_up_z,
   output logic             rsp_valid,
   output logic [1:0]       rsp_column_index,
   output logic [31:0]      rsp_row0,
   output logic [31:0]      rsp_row1,
   output logic [31:0]      rsp_row2,
   output logic [31:0]      rsp_row3,
   output logic             rsp_degenerate,
   output logic             rsp_last_column
);

   localparam int WORD_W = vlam_pkg::WORD_W;
   localparam int UNIT_W = vlam_pkg::UNIT_W;
   localparam int V32_W  = 3 * WORD_W;
   localparam int VU_W   = 3 * UNIT_W;
   localparam int AUX1_W = 2 * V32_W;
   localparam int AUX2_W = V32_W + VU_W + 1;
   localparam int AUX3_W = V32_W + 2 * VU_W + 1;
   localparam int Q_W    = vlam_pkg::DOT_W - vlam_pkg::FRAC_W;
   localparam logic signed [vlam_pkg::DOT_W-1:0] ROUND_HALF =
      vlam_pkg::DOT_W'(1) << (vlam_pkg::FRAC_W - 1);

   logic       accept;
   logic [1:0] gap_ff;

   // Front stage: exact difference target - eye.
   logic                         v0_ff;
   logic [2:0][vlam_pkg::DIFF_W-1:0] d_ff;
   vlam_pkg::vec32_type          eye0_ff;
   vlam_pkg::vec32_type          up0_ff;

   logic                  n1_valid, n1_zero;
   vlam_pkg::vecu_type    n1_vec;
   logic [AUX1_W-1:0]     n1_aux;
   vlam_pkg::vec32_type   n1_eye, n1_up;

   logic                           c1a_v_ff, c1b_v_ff;
   logic signed [vlam_pkg::PR1_W-1:0] p1_ff [6];
   logic [2:0][vlam_pkg::CR1_W-1:0]   cr1_ff;
   vlam_pkg::vec32_type            eye_c1a_ff, eye_c1b_ff;
   vlam_pkg::vecu_type             f_c1a_ff, f_c1b_ff;
   logic                           z_c1a_ff, z_c1b_ff;

   logic                  n2_valid, n2_zero;
   vlam_pkg::vecu_type    n2_vec;
   logic [AUX2_W-1:0]     n2_aux;
   vlam_pkg::vec32_type   n2_eye;
   vlam_pkg::vecu_type    n2_f;

   logic                           c2a_v_ff, c2b_v_ff;
   logic signed [vlam_pkg::PR2_W-1:0] p2_ff [6];
   logic [2:0][vlam_pkg::CR2_W-1:0]   cr2_ff;
   vlam_pkg::vec32_type            eye_c2a_ff, eye_c2b_ff;
   vlam_pkg::vecu_type             f_c2a_ff, f_c2b_ff, s_c2a_ff, s_c2b_ff;
   logic                           z_c2a_ff, z_c2b_ff;

   logic                  n3_valid, n3_zero;
   vlam_pkg::vecu_type    n3_vec;
   logic [AUX3_W-1:0]     n3_aux;
   vlam_pkg::vec32_type   n3_eye;
   vlam_pkg::vecu_type    n3_f, n3_s;

   // Translation stages; rows are s, u, f.
   logic                  da_v_ff, db_v_ff, dc_v_ff;
   logic signed [vlam_pkg::PR1_W-1:0] dp_ff [3][3];
   logic signed [Q_W-1:0]             q_ff [3];
   logic [2:0][WORD_W-1:0]            tr_ff;
   logic signed [vlam_pkg::DOT_W-1:0] t_sum [3];
   logic signed [Q_W:0]               nq [3];
   logic [2:0][WORD_W-1:0]            tr_in;
   vlam_pkg::vecu_type    s_da_ff, u_da_ff, f_da_ff;
   vlam_pkg::vecu_type    s_db_ff, u_db_ff, f_db_ff;
   vlam_pkg::vecu_type    s_dc_ff, u_dc_ff, f_dc_ff;
   logic                  g_da_ff, g_db_ff, g_dc_ff;

   // Column sequencer.
   logic                   active_ff;
   logic [1:0]             cnt_ff;
   vlam_pkg::vecu_type     hs_ff, hu_ff, hf_ff;
   logic [2:0][WORD_W-1:0] ht_ff;
   logic                   hg_ff;

   assign busy   = (gap_ff != 2'd0);
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff <= 2'd0;
         v0_ff  <= 1'b0;
      end else begin
         gap_ff <= accept ? vlam_pkg::COL_LAST : (busy ? gap_ff - 2'd1 : gap_ff);
         v0_ff  <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         d_ff[0] <= {req_target_x[31], req_target_x} - {req_eye_x[31], req_eye_x};
         d_ff[1] <= {req_target_y[31], req_target_y} - {req_eye_y[31], req_eye_y};
         d_ff[2] <= {req_target_z[31], req_target_z} - {req_eye_z[31], req_eye_z};
         eye0_ff <= {req_eye_z, req_eye_y, req_eye_x};
         up0_ff  <= {req_up_z, req_up_y, req_up_x};
      end
   end

   vlam_normalize #(
      .IN_W  (vlam_pkg::DIFF_W),
      .AUX_W (AUX1_W)
   ) u_norm_f (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v0_ff),
      .in_vec    (d_ff),
      .in_aux    ({eye0_ff, up0_ff}),
      .out_vec   (n1_vec),
      .out_valid (n1_valid),
      .out_zero  (n1_zero),
      .out_aux   (n1_aux)
   );

   assign n1_eye = n1_aux[AUX1_W-1 -: V32_W];
   assign n1_up  = n1_aux[V32_W-1:0];

   // s direction: up x f.
   always_ff @(posedge clock) begin
      if (reset) begin
         c1a_v_ff <= 1'b0;
         c1b_v_ff <= 1'b0;
      end else begin
         c1a_v_ff <= n1_valid;
         c1b_v_ff <= c1a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff[0] <= vlam_pkg::PR1_W'(signed'(n1_up[1])) * vlam_pkg::PR1_W'(signed'(n1_vec[2]));
      p1_ff[1] <= vlam_pkg::PR1_W'(signed'(n1_vec[1])) * vlam_pkg::PR1_W'(signed'(n1_up[2]));
      p1_ff[2] <= vlam_pkg::PR1_W'(signed'(n1_up[2])) * vlam_pkg::PR1_W'(signed'(n1_vec[0]));
      p1_ff[3] <= vlam_pkg::PR1_W'(signed'(n1_vec[2])) * vlam_pkg::PR1_W'(signed'(n1_up[0]));
      p1_ff[4] <= vlam_pkg::PR1_W'(signed'(n1_up[0])) * vlam_pkg::PR1_W'(signed'(n1_vec[1]));
      p1_ff[5] <= vlam_pkg::PR1_W'(signed'(n1_vec[0])) * vlam_pkg::PR1_W'(signed'(n1_up[1]));
      eye_c1a_ff <= n1_eye;
      f_c1a_ff   <= n1_vec;
      z_c1a_ff   <= n1_zero;
      for (int i = 0; i < 3; i++) begin
         cr1_ff[i] <= vlam_pkg::CR1_W'(p1_ff[2*i]) - vlam_pkg::CR1_W'(p1_ff[2*i+1]);
      end
      eye_c1b_ff <= eye_c1a_ff;
      f_c1b_ff   <= f_c1a_ff;
      z_c1b_ff   <= z_c1a_ff;
   end

   vlam_normalize #(
      .IN_W  (vlam_pkg::CR1_W),
      .AUX_W (AUX2_W)
   ) u_norm_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1b_v_ff),
      .in_vec    (cr1_ff),
      .in_aux    ({eye_c1b_ff, f_c1b_ff, z_c1b_ff}),
      .out_vec   (n2_vec),
      .out_valid (n2_valid),
      .out_zero  (n2_zero),
      .out_aux   (n2_aux)
   );

   assign n2_eye = n2_aux[AUX2_W-1 -: V32_W];
   assign n2_f   = n2_aux[VU_W:1];

   // u direction: f x s.
   always_ff @(posedge clock) begin
      if (reset) begin
         c2a_v_ff <= 1'b0;
         c2b_v_ff <= 1'b0;
      end else begin
         c2a_v_ff <= n2_valid;
         c2b_v_ff <= c2a_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_ff[0] <= vlam_pkg::PR2_W'(signed'(n2_f[1])) * vlam_pkg::PR2_W'(signed'(n2_vec[2]));
      p2_ff[1] <= vlam_pkg::PR2_W'(signed'(n2_vec[1])) * vlam_pkg::PR2_W'(signed'(n2_f[2]));
      p2_ff[2] <= vlam_pkg::PR2_W'(signed'(n2_f[2])) * vlam_pkg::PR2_W'(signed'(n2_vec[0]));
      p2_ff[3] <= vlam_pkg::PR2_W'(signed'(n2_vec[2])) * vlam_pkg::PR2_W'(signed'(n2_f[0]));
      p2_ff[4] <= vlam_pkg::PR2_W'(signed'(n2_f[0])) * vlam_pkg::PR2_W'(signed'(n2_vec[1]));
      p2_ff[5] <= vlam_pkg::PR2_W'(signed'(n2_vec[0])) * vlam_pkg::PR2_W'(signed'(n2_f[1]));
      eye_c2a_ff <= n2_eye;
      f_c2a_ff   <= n2_f;
      s_c2a_ff   <= n2_vec;
      z_c2a_ff   <= n2_aux[0] | n2_zero;
      for (int i = 0; i < 3; i++) begin
         cr2_ff[i] <= vlam_pkg::CR2_W'(p2_ff[2*i]) - vlam_pkg::CR2_W'(p2_ff[2*i+1]);
      end
      eye_c2b_ff <= eye_c2a_ff;
      f_c2b_ff   <= f_c2a_ff;
      s_c2b_ff   <= s_c2a_ff;
      z_c2b_ff   <= z_c2a_ff;
   end

   vlam_normalize #(
      .IN_W  (vlam_pkg::CR2_W),
      .AUX_W (AUX3_W)
   ) u_norm_u (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2b_v_ff),
      .in_vec    (cr2_ff),
      .in_aux    ({eye_c2b_ff, f_c2b_ff, s_c2b_ff, z_c2b_ff}),
      .out_vec   (n3_vec),
      .out_valid (n3_valid),
      .out_zero  (n3_zero),
      .out_aux   (n3_aux)
   );

   assign n3_eye = n3_aux[AUX3_W-1 -: V32_W];
   assign n3_f   = n3_aux[2*VU_W -: VU_W];
   assign n3_s   = n3_aux[VU_W:1];

   // Translation: -dot(n, eye) at Q21.32, rounded half up, then saturated.
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         t_sum[r] = vlam_pkg::DOT_W'(dp_ff[r][0]) + vlam_pkg::DOT_W'(dp_ff[r][1])
                  + vlam_pkg::DOT_W'(dp_ff[r][2]) + ROUND_HALF;
         nq[r]    = -((Q_W+1)'(q_ff[r]));
         if ((&nq[r][Q_W:WORD_W-1]) || !(|nq[r][Q_W:WORD_W-1])) begin
            tr_in[r] = nq[r][WORD_W-1:0];
         end else if (nq[r][Q_W]) begin
            tr_in[r] = {1'b1, {(WORD_W-1){1'b0}}};
         end else begin
            tr_in[r] = {1'b0, {(WORD_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         da_v_ff <= 1'b0;
         db_v_ff <= 1'b0;
         dc_v_ff <= 1'b0;
      end else begin
         da_v_ff <= n3_valid;
         db_v_ff <= da_v_ff;
         dc_v_ff <= db_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         dp_ff[0][k] <= vlam_pkg::PR1_W'(signed'(n3_s[k])) * vlam_pkg::PR1_W'(signed'(n3_eye[k]));
         dp_ff[1][k] <= vlam_pkg::PR1_W'(signed'(n3_vec[k])) * vlam_pkg::PR1_W'(signed'(n3_eye[k]));
         dp_ff[2][k] <= vlam_pkg::PR1_W'(signed'(n3_f[k])) * vlam_pkg::PR1_W'(signed'(n3_eye[k]));
      end
      s_da_ff <= n3_s;
      u_da_ff <= n3_vec;
      f_da_ff <= n3_f;
      g_da_ff <= n3_aux[0] | n3_zero;
      for (int r = 0; r < 3; r++) begin
         q_ff[r] <= t_sum[r][vlam_pkg::DOT_W-1:vlam_pkg::FRAC_W];
      end
      s_db_ff <= s_da_ff;
      u_db_ff <= u_da_ff;
      f_db_ff <= f_da_ff;
      g_db_ff <= g_da_ff;
      tr_ff   <= tr_in;
      s_dc_ff <= s_db_ff;
      u_dc_ff <= u_db_ff;
      f_dc_ff <= f_db_ff;
      g_dc_ff <= g_db_ff;
   end

   // A finished matrix is held and sent as four columns on consecutive cycles.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else if (dc_v_ff) begin
         active_ff <= 1'b1;
         cnt_ff    <= 2'd0;
      end else if (active_ff) begin
         active_ff <= (cnt_ff != vlam_pkg::COL_LAST);
         cnt_ff    <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (dc_v_ff) begin
         hs_ff <= s_dc_ff;
         hu_ff <= u_dc_ff;
         hf_ff <= f_dc_ff;
         ht_ff <= tr_ff;
         hg_ff <= g_dc_ff;
      end
   end

   always_comb begin
      if (cnt_ff == vlam_pkg::COL_LAST) begin
         rsp_row0 = ht_ff[0];
         rsp_row1 = ht_ff[1];
         rsp_row2 = ht_ff[2];
         rsp_row3 = vlam_pkg::FIX_ONE;
      end else begin
         rsp_row0 = WORD_W'(signed'(hs_ff[cnt_ff]));
         rsp_row1 = WORD_W'(signed'(hu_ff[cnt_ff]));
         rsp_row2 = WORD_W'(signed'(hf_ff[cnt_ff]));
         rsp_row3 = '0;
      end
   end

   assign rsp_valid        = active_ff;
   assign rsp_column_index = cnt_ff;
   assign rsp_degenerate   = hg_ff;
   assign rsp_last_column  = active_ff && (cnt_ff == vlam_pkg::COL_LAST);

`ifndef NO_ASSERTIONS
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy did not rise after an accepted request");

   a_columns_in_order : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_column) |=>
         (rsp_valid && rsp_column_index == 2'($past(rsp_column_index) + 2'd1)))
      else $error("matrix columns were not sent back to back in order");

   a_last_column : assert property (@(posedge clock) disable iff (reset)
      rsp_last_column |-> (rsp_column_index == vlam_pkg::COL_LAST &&
                           rsp_row3 == vlam_pkg::FIX_ONE))
      else $error("last column flag on a column other than the translation");

   a_degenerate_stable : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_column) |=> $stable(rsp_degenerate))
      else $error("degenerate flag changed within one matrix");
`endif

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Checks the look-at view matrix block. Requests come from a table of directed
// cases and then from random cameras; a predictor computes the four expected
// columns per request, and every result strobe is compared against them.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int LATENCY    = 120;
   localparam int WDOG_LIMIT = 4000;
   localparam int N_RANDOM   = 240;

   typedef struct packed {
      logic [1:0]  col;
      logic [31:0] r0;
      logic [31:0] r1;
      logic [31:0] r2;
      logic [31:0] r3;
      logic        degen;
      logic        last;
   } column_type;

   typedef struct {
      logic [31:0] eye[3];
      logic [31:0] tgt[3];
      logic [31:0] up[3];
   } camera_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] eye_x, eye_y, eye_z, tgt_x, tgt_y, tgt_z, up_x, up_y, up_z;
   logic        rsp_valid;
   logic [1:0]  rsp_column_index;
   logic [31:0] rsp_row0, rsp_row1, rsp_row2, rsp_row3;
   logic        rsp_degenerate, rsp_last_column;

   column_type  columns_due[$];
   int          errors;
   int          idle_pct;
   int          wdog;
   int          n_requests;
   int          n_columns;
   int          n_degen;

   view_look_at_matrix_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_eye_x(eye_x), .req_eye_y(eye_y), .req_eye_z(eye_z),
      .req_target_x(tgt_x), .req_target_y(tgt_y), .req_target_z(tgt_z),
      .req_up_x(up_x), .req_up_y(up_y), .req_up_z(up_z),
      .rsp_valid(rsp_valid), .rsp_column_index(rsp_column_index),
      .rsp_row0(rsp_row0), .rsp_row1(rsp_row1), .rsp_row2(rsp_row2),
      .rsp_row3(rsp_row3), .rsp_degenerate(rsp_degenerate),
      .rsp_last_column(rsp_last_column)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic logic [63:0] floor_sqrt(logic [63:0] x);
      logic [63:0] root;
      logic [63:0] bitv;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= root + bitv) begin
            x = x - (root + bitv);
            root = (root >> 1) + bitv;
         end else begin
            root = root >> 1;
         end
         bitv = bitv >> 2;
      end
      return root;
   endfunction

   // Returns 1 when the vector has zero length.
   function automatic logic unit_vector(input longint v[3], output longint o[3]);
      logic [63:0] mag[3];
      logic [63:0] big, total, len, q;
      big = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (v[i] < 0) ? -v[i] : v[i];
         if (mag[i] > big) big = mag[i];
      end
      if (big == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return 1'b1;
      end
      while (big >= (64'h1 << 31)) begin
         big = big >> 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      end
      while (big < (64'h1 << 30)) begin
         big = big << 1;
         for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      end
      total = 0;
      for (int i = 0; i < 3; i++) total = total + mag[i] * mag[i];
      len = floor_sqrt(total);
      for (int i = 0; i < 3; i++) begin
         q = (mag[i] * 64'd65536 + (len >> 1)) / len;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic void cross_product(input longint a[3], input longint b[3],
                                         output longint o[3]);
      o[0] = a[1] * b[2] - b[1] * a[2];
      o[1] = a[2] * b[0] - b[2] * a[0];
      o[2] = a[0] * b[1] - b[0] * a[1];
   endfunction

   // Negated translation term: Q32.32 dot rounded half up, then saturated.
   function automatic logic [31:0] translation(input longint n[3], input longint e[3]);
      longint t, q;
      t = n[0] * e[0] + n[1] * e[1] + n[2] * e[2] + 32768;
      q = t >>> 16;
      q = -q;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   task automatic predict_matrix(input camera_type cam);
      longint e[3], d[3], u_in[3], f[3], s[3], u[3], tmp[3];
      logic degen;
      column_type c;
      for (int i = 0; i < 3; i++) begin
         e[i] = longint'($signed(cam.eye[i]));
         d[i] = longint'($signed(cam.tgt[i])) - e[i];
         u_in[i] = longint'($signed(cam.up[i]));
      end
      degen = unit_vector(d, f);
      cross_product(u_in, f, tmp);
      degen = unit_vector(tmp, s) | degen;
      cross_product(f, s, tmp);
      degen = unit_vector(tmp, u) | degen;
      for (int k = 0; k < 3; k++) begin
         c.col = 2'(k);
         c.r0 = s[k][31:0];
         c.r1 = u[k][31:0];
         c.r2 = f[k][31:0];
         c.r3 = '0;
         c.degen = degen;
         c.last = 1'b0;
         columns_due.push_back(c);
      end
      c.col = vlam_pkg::COL_LAST;
      c.r0 = translation(s, e);
      c.r1 = translation(u, e);
      c.r2 = translation(f, e);
      c.r3 = vlam_pkg::FIX_ONE;
      c.degen = degen;
      c.last = 1'b1;
      columns_due.push_back(c);
      if (degen) n_degen++;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
   endtask

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         column_type want;
         n_columns++;
         if (columns_due.size() == 0) begin
            errors++;
            $display("unexpected result column %0d at %0t", rsp_column_index, $time);
         end else begin
            want = columns_due.pop_front();
            if (rsp_column_index !== want.col)
               report_mismatch("column_index", 32'(rsp_column_index), 32'(want.col));
            if (rsp_row0 !== want.r0) report_mismatch("row0", rsp_row0, want.r0);
            if (rsp_row1 !== want.r1) report_mismatch("row1", rsp_row1, want.r1);
            if (rsp_row2 !== want.r2) report_mismatch("row2", rsp_row2, want.r2);
            if (rsp_row3 !== want.r3) report_mismatch("row3", rsp_row3, want.r3);
            if (rsp_degenerate !== want.degen)
               report_mismatch("degenerate", 32'(rsp_degenerate), 32'(want.degen));
            if (rsp_last_column !== want.last)
               report_mismatch("last_column", 32'(rsp_last_column), 32'(want.last));
         end
      end
   end

   // Watchdog: counts cycles with no request and no result accepted.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         wdog <= 0;
      end else begin
         wdog <= wdog + 1;
         if (wdog >= WDOG_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   // Start stays high from one request to the next when the sender does not
   // pause; it drops only for idle cycles.
   task automatic send_request(input camera_type cam);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      eye_x <= cam.eye[0]; eye_y <= cam.eye[1]; eye_z <= cam.eye[2];
      tgt_x <= cam.tgt[0]; tgt_y <= cam.tgt[1]; tgt_z <= cam.tgt[2];
      up_x <= cam.up[0]; up_y <= cam.up[1]; up_z <= cam.up[2];
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_matrix(cam);
      n_requests++;
   endtask

   function automatic logic [31:0] random_word();
      case ($urandom_range(5))
         0: return 32'h8000_0000 + $urandom_range(3);
         1: return 32'h7fff_ffff - $urandom_range(3);
         2: return 32'($signed($urandom_range(20)) - 10) << 16;
         3: return 32'($signed($urandom_range(65535)) - 32768);
         default: return $urandom;
      endcase
   endfunction

   function automatic camera_type random_camera();
      camera_type cam;
      for (int i = 0; i < 3; i++) begin
         cam.eye[i] = random_word();
         cam.tgt[i] = random_word();
         cam.up[i] = random_word();
      end
      // Now and then aim along up or collapse a vector to hit the zero cases.
      case ($urandom_range(15))
         0: cam.tgt = cam.eye;
         1: for (int i = 0; i < 3; i++) cam.up[i] = '0;
         2: for (int i = 0; i < 3; i++) cam.tgt[i] = cam.eye[i] + cam.up[i];
         default: ;
      endcase
      return cam;
   endfunction

   // Directed table: eye, target, up. Hand-written expectations cover the identity
   // camera and the zero-forward degenerate flag; the rest use the predictor.
   localparam int N_DIRECTED = 12;
   logic [31:0] directed[N_DIRECTED][9] = '{
      '{0, 0, 0, 0, 0, 32'h0001_0000, 0, 32'h0001_0000, 0},
      '{0, 0, 0, 0, 0, 0, 0, 32'h0001_0000, 0},
      '{0, 0, 0, 0, 32'h0001_0000, 0, 0, 32'h0001_0000, 0},
      '{0, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff},
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000},
      '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
        32'h7fff_ffff, 32'h8000_0000, 32'h8000_0001,
        0, 32'h0001_0000, 0},
      '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
        32'hffff_ffff, 32'hffff_ffff, 32'h0000_0000,
        32'h0000_0001, 32'h0000_0000, 32'h0000_0000},
      '{32'h0003_0000, 32'hfffe_0000, 32'h0005_0000,
        32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
        32'h0000_8000, 32'h0001_0000, 32'hffff_8000},
      '{32'h1234_5678, 32'h8765_4321, 32'h0bad_f00d,
        32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333,
        32'hffff_ffff, 32'h0000_0001, 32'h8000_0000},
      '{0, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000},
      '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
        32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
        0, 32'h0001_0000, 0}
   };

   initial begin
      camera_type cam;
      errors = 0;
      n_requests = 0;
      n_columns = 0;
      n_degen = 0;
      idle_pct = 0;
      reset = 1'b1;
      start = 1'b0;
      {eye_x, eye_y, eye_z, tgt_x, tgt_y, tgt_z, up_x, up_y, up_z} = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < N_DIRECTED; r++) begin
         for (int i = 0; i < 3; i++) begin
            cam.eye[i] = directed[r][i];
            cam.tgt[i] = directed[r][3 + i];
            cam.up[i] = directed[r][6 + i];
         end
         send_request(cam);
         // The identity camera has a known matrix; check the predictor too.
         if (r == 0 && (columns_due[0].r0 !== 32'h0001_0000 ||
                        columns_due[1].r1 !== 32'h0001_0000 ||
                        columns_due[2].r2 !== 32'h0001_0000 ||
                        columns_due[3].r2 !== 32'h0000_0000 ||
                        columns_due[0].degen !== 1'b0))
            report_mismatch("identity camera prediction", 0, 0);
         if (r == 1 && columns_due[columns_due.size() - 1].degen !== 1'b1)
            report_mismatch("zero forward prediction", 0, 1);
      end
      start <= 1'b0;

      // Sender holds off until every column has drained.
      while (columns_due.size() != 0) @(posedge clock);

      for (int n = 0; n < N_RANDOM; n++) begin
         case (n / 60)
            0: idle_pct = 0;
            1: idle_pct = 73;
            2: idle_pct = 0;
            default: idle_pct = 33;
         endcase
         send_request(random_camera());
      end
      start <= 1'b0;

      while (columns_due.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);

      $display("%0d requests, %0d columns checked, %0d with a zero-length vector",
               n_requests, n_columns, n_degen);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
